// ===== design/bps_pkg.sv =====
package bps_pkg;

   localparam int MAX_PERIODS = 64;
   localparam int CNT_W       = 7;
   localparam int DIV_STEPS   = 93;
   localparam int DEN_W       = 34;
   localparam int REM_W       = DEN_W + 1;

   localparam logic [31:0] YIELD_STEP = 32'd429497;
   localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
   localparam logic [63:0] PRICE_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] GAMMA_MULT = 64'd20000;

   typedef struct packed {
      logic [31:0] yield_rate;
      logic [6:0]  maturity_halfyears;
      logic [6:0]  coupon_count;
      logic [39:0] coupon_amount;
      logic [39:0] face_value;
      logic [31:0] yield_deviation;
   } req_data_type;

   typedef struct packed {
      logic [62:0]        price;
      logic [62:0]        price_up;
      logic [62:0]        price_down;
      logic signed [63:0] price_delta;
      logic signed [63:0] price_gamma;
      logic signed [63:0] risk_value;
   } rsp_data_type;

   typedef enum logic [1:0] {SH_Q60, SH_Q36, SH_Q1, SH_Q16} mul_shift_type;

   typedef struct packed {
      logic          start;
      logic [63:0]   op_a;
      logic [63:0]   op_b;
      mul_shift_type shift;
      logic [63:0]   limit;
   } mul_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } mul_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_F0_GO, ST_F0_WAIT, ST_LOOP_CHK,
      ST_P_GO, ST_P_WAIT, ST_C_GO, ST_C_WAIT, ST_FC_GO, ST_FC_WAIT, ST_K_NEXT,
      ST_YIELD_END, ST_G_GO, ST_G_WAIT, ST_R_GO, ST_R_WAIT, ST_OUT
   } state_type;

endpackage

// ===== design/bond_price_sensitivity_unit.sv =====
// Bond price sensitivity unit.
// Input channel req_valid/req_ready/req_data carries one bond per transaction;
// result channel rsp_valid/rsp_ready/rsp_data returns one result per bond.
// The bond is priced at the yield, yield + 1bp and yield - 1bp, then delta,
// gamma and risk are formed. All products and quotients come from one 64x64
// multiplier (32x32 partial product per cycle) and one radix-2 reciprocal
// divider (93 steps). One bond is in work at a time; req_ready is high only
// while the sequencer is idle. The result sits in an output register; a new
// bond is accepted while it waits. If the receiver stalls, the finished next
// result holds in the sequencer until the output register frees.
// Synchronous reset clears the sequencer and rsp_valid; no clearing pass.
module bond_price_sensitivity_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bps_pkg::req_data_type  req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bps_pkg::rsp_data_type  rsp_data
);
   import bps_pkg::*;

   state_type        state_ff, state_in;
   req_data_type     item_ff, item_in;
   logic [CNT_W-1:0] m_ff, m_in, n_ff, n_in, last_ff, last_in, k_ff, k_in;
   logic [1:0]       yidx_ff, yidx_in;
   logic [63:0]      d_ff, d_in, p_ff, p_in;
   logic [62:0]      sum_ff, sum_in, pr_ff, pr_in, up_ff, up_in, dn_ff, dn_in;
   logic [63:0]      gmag_ff, gmag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_data_type     rsp_ff, rsp_in;

   mul_cmd_type      mcmd;
   mul_rsp_type      mrsp;
   logic             div_start, div_done;
   logic [DEN_W-1:0] den;
   logic [63:0]      quot;

   logic [CNT_W-1:0] m_cl, n_cl;
   logic [63:0]      term_sum;
   logic             dneg, gneg;
   logic [63:0]      dmag, ga, gb, gdiff;
   logic [63:0]      rlimit;

   bps_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .den   (den),
      .done  (div_done),
      .quot  (quot)
   );

   bps_multiplier u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mcmd),
      .rsp   (mrsp)
   );

   always_comb begin
      m_cl = (req_data.maturity_halfyears > CNT_W'(MAX_PERIODS)) ? CNT_W'(MAX_PERIODS)
                                                                : req_data.maturity_halfyears;
      n_cl = (req_data.coupon_count > CNT_W'(MAX_PERIODS)) ? CNT_W'(MAX_PERIODS)
                                                          : req_data.coupon_count;
      unique case (yidx_ff)
         2'd1:    den = DEN_W'(34'h2_0000_0000) + DEN_W'(item_ff.yield_rate)
                        + DEN_W'(YIELD_STEP);
         2'd2:    den = DEN_W'(34'h2_0000_0000) + DEN_W'(item_ff.yield_rate)
                        - DEN_W'(YIELD_STEP);
         default: den = DEN_W'(34'h2_0000_0000) + DEN_W'(item_ff.yield_rate);
      endcase
      term_sum = {1'b0, sum_ff} + mrsp.result;
      if (term_sum > PRICE_MAX) term_sum = PRICE_MAX;
      dneg  = up_ff < dn_ff;
      dmag  = dneg ? ({1'b0, dn_ff - up_ff} >> 1) : ({1'b0, up_ff - dn_ff} >> 1);
      ga    = {1'b0, up_ff} + {1'b0, dn_ff};
      gb    = {pr_ff, 1'b0};
      gneg  = ga < gb;
      gdiff = gneg ? gb - ga : ga - gb;
      rlimit = dneg ? NEG_LIMIT : PRICE_MAX;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      yidx_in      = yidx_ff;
      d_in         = d_ff;
      p_in         = p_ff;
      sum_in       = sum_ff;
      pr_in        = pr_ff;
      up_in        = up_ff;
      dn_in        = dn_ff;
      gmag_in      = gmag_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_start    = 1'b0;
      mcmd.start   = 1'b0;
      mcmd.op_a    = 64'(item_ff.face_value);
      mcmd.op_b    = p_ff;
      mcmd.shift   = SH_Q36;
      mcmd.limit   = PRICE_MAX;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_data;
               m_in     = m_cl;
               n_in     = n_cl;
               last_in  = (n_cl > m_cl) ? n_cl : m_cl;
               yidx_in  = '0;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               d_in     = quot;
               p_in     = ONE_Q60;
               sum_in   = '0;
               k_in     = CNT_W'(1);
               state_in = (m_ff == '0) ? ST_F0_GO : ST_LOOP_CHK;
            end
         end
         ST_F0_GO: begin
            mcmd.start = 1'b1;
            state_in   = ST_F0_WAIT;
         end
         ST_F0_WAIT: begin
            if (mrsp.done) begin
               sum_in   = term_sum[62:0];
               state_in = ST_LOOP_CHK;
            end
         end
         ST_LOOP_CHK: begin
            state_in = (k_ff > last_ff) ? ST_YIELD_END : ST_P_GO;
         end
         ST_P_GO: begin
            mcmd.start = 1'b1;
            mcmd.op_a  = p_ff;
            mcmd.op_b  = d_ff;
            mcmd.shift = SH_Q60;
            mcmd.limit = ALL_ONES;
            state_in   = ST_P_WAIT;
         end
         ST_P_WAIT: begin
            if (mrsp.done) begin
               p_in = mrsp.result;
               if (k_ff <= n_ff) state_in = ST_C_GO;
               else if (k_ff == m_ff) state_in = ST_FC_GO;
               else state_in = ST_K_NEXT;
            end
         end
         ST_C_GO: begin
            mcmd.start = 1'b1;
            mcmd.op_a  = 64'(item_ff.coupon_amount);
            state_in   = ST_C_WAIT;
         end
         ST_C_WAIT: begin
            if (mrsp.done) begin
               sum_in   = term_sum[62:0];
               state_in = (k_ff == m_ff) ? ST_FC_GO : ST_K_NEXT;
            end
         end
         ST_FC_GO: begin
            mcmd.start = 1'b1;
            state_in   = ST_FC_WAIT;
         end
         ST_FC_WAIT: begin
            if (mrsp.done) begin
               sum_in   = term_sum[62:0];
               state_in = ST_K_NEXT;
            end
         end
         ST_K_NEXT: begin
            k_in     = k_ff + CNT_W'(1);
            state_in = ST_LOOP_CHK;
         end
         ST_YIELD_END: begin
            unique case (yidx_ff)
               2'd0:    pr_in = sum_ff;
               2'd1:    up_in = sum_ff;
               default: dn_in = sum_ff;
            endcase
            if (yidx_ff == 2'd2) begin
               state_in = ST_G_GO;
            end else begin
               yidx_in  = yidx_ff + 2'd1;
               state_in = ST_DIV_GO;
            end
         end
         ST_G_GO: begin
            mcmd.start = 1'b1;
            mcmd.op_a  = gdiff;
            mcmd.op_b  = GAMMA_MULT;
            mcmd.shift = SH_Q1;
            mcmd.limit = gneg ? NEG_LIMIT : PRICE_MAX;
            state_in   = ST_G_WAIT;
         end
         ST_G_WAIT: begin
            if (mrsp.done) begin
               gmag_in  = gneg ? 64'd0 - mrsp.result : mrsp.result;
               state_in = ST_R_GO;
            end
         end
         ST_R_GO: begin
            mcmd.start = 1'b1;
            mcmd.op_a  = dmag;
            mcmd.op_b  = 64'(item_ff.yield_deviation);
            mcmd.shift = SH_Q16;
            mcmd.limit = rlimit;
            state_in   = ST_R_WAIT;
         end
         ST_R_WAIT: begin
            if (mrsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.price       = pr_ff;
               rsp_in.price_up    = up_ff;
               rsp_in.price_down  = dn_ff;
               rsp_in.price_delta = dneg ? 64'd0 - dmag : dmag;
               rsp_in.price_gamma = gmag_ff;
               rsp_in.risk_value  = dneg ? 64'd0 - mrsp.result : mrsp.result;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      m_ff    <= m_in;
      n_ff    <= n_in;
      last_ff <= last_in;
      k_ff    <= k_in;
      yidx_ff <= yidx_in;
      d_ff    <= d_in;
      p_ff    <= p_in;
      sum_ff  <= sum_in;
      pr_ff   <= pr_in;
      up_ff   <= up_in;
      dn_ff   <= dn_in;
      gmag_ff <= gmag_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/bps_divider.sv =====
module bps_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bps_pkg::DEN_W-1:0]  den,
   output logic                       done,
   output logic [63:0]                quot
);
   import bps_pkg::*;

   logic [REM_W-1:0] rem_ff, rem_in, rem_sh;
   logic [63:0]      quot_ff, quot_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      rem_sh  = {rem_ff[REM_W-2:0], 1'b0};
      if (start) begin
         rem_in  = REM_W'(1);
         quot_in = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in  = rem_sh - {1'b0, den_ff};
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== design/bps_multiplier.sv =====
module bps_multiplier (
   input  logic                  clock,
   input  logic                  reset,
   input  bps_pkg::mul_cmd_type  cmd,
   output bps_pkg::mul_rsp_type  rsp
);
   import bps_pkg::*;

   logic [63:0]   a_ff, a_in, b_ff, b_in, lim_ff, lim_in;
   mul_shift_type sh_ff, sh_in;
   logic [127:0]  acc_ff, acc_in, pp_ext, shifted;
   logic [1:0]    idx_ff, idx_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [31:0]   a_half, b_half;
   logic [63:0]   pp;

   always_comb begin
      a_half = idx_ff[0] ? a_ff[63:32] : a_ff[31:0];
      b_half = idx_ff[1] ? b_ff[63:32] : b_ff[31:0];
      pp     = a_half * b_half;
      pp_ext = {64'd0, pp} << (7'd32 * (7'(idx_ff[0]) + 7'(idx_ff[1])));
      a_in    = a_ff;
      b_in    = b_ff;
      lim_in  = lim_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (cmd.start) begin
         a_in    = cmd.op_a;
         b_in    = cmd.op_b;
         lim_in  = cmd.limit;
         sh_in   = cmd.shift;
         acc_in  = '0;
         idx_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_ext;
         idx_in = idx_ff + 2'd1;
         if (idx_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (sh_ff)
         SH_Q60:  shifted = acc_ff >> 60;
         SH_Q36:  shifted = acc_ff >> 36;
         SH_Q1:   shifted = acc_ff >> 1;
         SH_Q16:  shifted = acc_ff >> 16;
         default: shifted = acc_ff;
      endcase
      rsp.done   = done_ff;
      rsp.result = (shifted[127:64] != '0 || shifted[63:0] > lim_ff) ? lim_ff
                                                                      : shifted[63:0];
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      lim_ff <= lim_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      idx_ff <= idx_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule
